>>> design/weighted_union_find_unit_defines.svh
// ----------------------------------------------------------------------------
// weighted union-find unit assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_UNION_FIND_UNIT_DEFINES_SVH
`define WEIGHTED_UNION_FIND_UNIT_DEFINES_SVH

// next-cycle implication, quiet while reset is asserted
`define WUFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define WUFU_ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/wufu_pkg.sv
// ----------------------------------------------------------------------------
// wufu_pkg
// shared widths and types of the weighted union-find unit
// ----------------------------------------------------------------------------
package wufu_pkg;

    // width of a node number on the item channels
    localparam int unsigned NODE_W = 10;

    // one result item
    typedef struct packed {
        logic              conn;
        logic [NODE_W-1:0] root;
    } t_result;

    // per-cycle memory strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

endpackage

>>> design/wufu_if.sv
// ----------------------------------------------------------------------------
// wufu_req_if / wufu_rsp_if
// valid/ready channels carrying node pairs in and connectivity results out
// ----------------------------------------------------------------------------
interface wufu_req_if;
    import wufu_pkg::*;

    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;

    modport source (output valid, output first_node, output second_node, input ready);
    modport sink   (input valid, input first_node, input second_node, output ready);
endinterface

interface wufu_rsp_if;
    import wufu_pkg::*;

    logic              valid;
    logic              ready;
    logic              already_connected;
    logic [NODE_W-1:0] common_root;

    modport source (output valid, output already_connected, output common_root, input ready);
    modport sink   (input valid, input already_connected, input common_root, output ready);
endinterface

>>> design/wufu_ram.sv
// ----------------------------------------------------------------------------
// wufu_ram
// single-port-write, single-port-read memory with registered read data
// ----------------------------------------------------------------------------
module wufu_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 10
) (
    input  logic                         i_clk,
    input  wufu_pkg::t_ram_ctl           i_ctl,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]             i_wdata,
    output logic [WIDTH-1:0]             o_rdata
);
    import wufu_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/wufu_ctrl.sv
// ----------------------------------------------------------------------------
// wufu_ctrl
// sequencer: clearing pass, two root walks, weighted link and size update
// ----------------------------------------------------------------------------
module wufu_ctrl #(
    parameter int unsigned NODES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item start
    input  logic                                 i_start,
    input  logic [$clog2(NODES)-1:0]             i_first,
    input  logic [$clog2(NODES)-1:0]             i_second,
    output logic                                 o_idle,
    // result hand-off
    input  logic                                 i_emit_ok,
    output logic                                 o_res_valid,
    output wufu_pkg::t_result                    o_res,
    // parent link memory
    output wufu_pkg::t_ram_ctl                   o_par_ctl,
    output logic [$clog2(NODES)-1:0]             o_par_raddr,
    output logic [$clog2(NODES)-1:0]             o_par_waddr,
    output logic [$clog2(NODES)-1:0]             o_par_wdata,
    input  logic [$clog2(NODES)-1:0]             i_par_rdata,
    // tree size memory
    output wufu_pkg::t_ram_ctl                   o_sz_ctl,
    output logic [$clog2(NODES)-1:0]             o_sz_raddr,
    output logic [$clog2(NODES)-1:0]             o_sz_waddr,
    output logic [$clog2(NODES+1)-1:0]           o_sz_wdata,
    input  logic [$clog2(NODES+1)-1:0]           i_sz_rdata
);
    import wufu_pkg::*;

    localparam int unsigned IDX_W  = $clog2(NODES);
    localparam int unsigned SIZE_W = $clog2(NODES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_WALK_A = 6'b000100,
        ST_WALK_B = 6'b001000,
        ST_UNION  = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_second, n_second;
    logic [IDX_W-1:0]   r_root_a, n_root_a;
    logic [SIZE_W-1:0]  r_size_a, n_size_a;
    t_result            r_res, n_res;
    logic [SIZE_W-1:0]  size_sum;

    // merged tree size, never above the node count
    assign size_sum = r_size_a + i_sz_rdata;

    // next state and memory access
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_second    = r_second;
        n_root_a    = r_root_a;
        n_size_a    = r_size_a;
        n_res       = r_res;
        o_res_valid = 1'b0;
        o_par_ctl   = '0;
        o_par_raddr = r_cur;
        o_par_waddr = r_cnt;
        o_par_wdata = r_cnt;
        o_sz_ctl    = '0;
        o_sz_raddr  = r_cur;
        o_sz_waddr  = r_cnt;
        o_sz_wdata  = SIZE_W'(1);
        unique case (r_state)
            ST_CLEAR: begin
                // every node its own root with size one
                o_par_ctl.wr_en = 1'b1;
                o_sz_ctl.wr_en  = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_par_ctl.rd_en = 1'b1;
                    o_par_raddr     = i_first;
                    n_cur           = i_first;
                    n_second        = i_second;
                    n_state         = ST_WALK_A;
                end
            end
            ST_WALK_A: begin
                o_par_ctl.rd_en = 1'b1;
                if (i_par_rdata == r_cur) begin
                    // first root found, fetch its size and start the second walk
                    n_root_a       = r_cur;
                    o_sz_ctl.rd_en = 1'b1;
                    o_sz_raddr     = r_cur;
                    o_par_raddr    = r_second;
                    n_cur          = r_second;
                    n_state        = ST_WALK_B;
                end else begin
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            ST_WALK_B: begin
                if (i_par_rdata == r_cur) begin
                    if (r_cur == r_root_a) begin
                        n_res.conn = 1'b1;
                        n_res.root = NODE_W'(r_cur);
                        n_state    = ST_EMIT;
                    end else begin
                        // size of the first root is still on the read port
                        n_size_a       = i_sz_rdata;
                        o_sz_ctl.rd_en = 1'b1;
                        o_sz_raddr     = r_cur;
                        n_state        = ST_UNION;
                    end
                end else begin
                    o_par_ctl.rd_en = 1'b1;
                    o_par_raddr     = i_par_rdata;
                    n_cur           = i_par_rdata;
                end
            end
            ST_UNION: begin
                // smaller tree goes under the larger, ties under the first root
                o_par_ctl.wr_en = 1'b1;
                o_sz_ctl.wr_en  = 1'b1;
                o_sz_wdata      = size_sum;
                n_res.conn      = 1'b0;
                if (r_size_a < i_sz_rdata) begin
                    o_par_waddr = r_root_a;
                    o_par_wdata = r_cur;
                    o_sz_waddr  = r_cur;
                    n_res.root  = NODE_W'(r_cur);
                end else begin
                    o_par_waddr = r_cur;
                    o_par_wdata = r_root_a;
                    o_sz_waddr  = r_root_a;
                    n_res.root  = NODE_W'(r_root_a);
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_emit_ok) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_second <= n_second;
        r_root_a <= n_root_a;
        r_size_a <= n_size_a;
        r_res    <= n_res;
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_res  = r_res;

endmodule

>>> design/weighted_union_find_unit.sv
// ----------------------------------------------------------------------------
// weighted_union_find_unit
// weighted quick-union connectivity engine over NODES nodes
//
//   port     dir   modport   item
//   i_req    in    sink      first_node, second_node
//   o_rsp    out   source    already_connected, common_root
//
// an item walks from each of its nodes up to the root, then links the two trees
// unless they are already connected; each parent link step costs one parent memory read
// after reset a clearing pass over all NODES nodes fills both memories, i_req not ready
// a stalled o_rsp holds one result; the next item is still accepted and
// waits in its last step only while the held result is not yet taken
// ----------------------------------------------------------------------------
module weighted_union_find_unit #(
    parameter int unsigned NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wufu_req_if.sink    i_req,
    wufu_rsp_if.source  o_rsp
);
    import wufu_pkg::*;

    localparam int unsigned IDX_W  = $clog2(NODES);
    localparam int unsigned SIZE_W = $clog2(NODES + 1);

    logic              start;
    logic              idle;
    logic              emit_ok;
    logic              res_valid;
    t_result           res;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  second_idx;

    t_ram_ctl          par_ctl;
    logic [IDX_W-1:0]  par_raddr;
    logic [IDX_W-1:0]  par_waddr;
    logic [IDX_W-1:0]  par_wdata;
    logic [IDX_W-1:0]  par_rdata;

    t_ram_ctl          sz_ctl;
    logic [IDX_W-1:0]  sz_raddr;
    logic [IDX_W-1:0]  sz_waddr;
    logic [SIZE_W-1:0] sz_wdata;
    logic [SIZE_W-1:0] sz_rdata;

    logic              r_out_valid;
    logic              r_out_conn;
    logic [NODE_W-1:0] r_out_root;

    // out-of-range node numbers map to the last node
    function automatic logic [IDX_W-1:0] clamp_node(input logic [NODE_W-1:0] node);
        logic [IDX_W-1:0] idx;
        if (32'(node) >= NODES) begin
            idx = IDX_W'(NODES - 1);
        end else begin
            idx = IDX_W'(node);
        end
        return idx;
    endfunction

    // input side
    assign first_idx   = clamp_node(i_req.first_node);
    assign second_idx  = clamp_node(i_req.second_node);
    assign i_req.ready = idle;
    assign start       = i_req.valid & idle;

    // output slot is free or drains this cycle
    assign emit_ok = !r_out_valid || o_rsp.ready;

    wufu_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_first     (first_idx),
        .i_second    (second_idx),
        .o_idle      (idle),
        .i_emit_ok   (emit_ok),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_par_ctl   (par_ctl),
        .o_par_raddr (par_raddr),
        .o_par_waddr (par_waddr),
        .o_par_wdata (par_wdata),
        .i_par_rdata (par_rdata),
        .o_sz_ctl    (sz_ctl),
        .o_sz_raddr  (sz_raddr),
        .o_sz_waddr  (sz_waddr),
        .o_sz_wdata  (sz_wdata),
        .i_sz_rdata  (sz_rdata)
    );

    // parent link memory
    wufu_ram #(
        .DEPTH (NODES),
        .WIDTH (IDX_W)
    ) u_par_ram (
        .i_clk   (i_clk),
        .i_ctl   (par_ctl),
        .i_raddr (par_raddr),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .o_rdata (par_rdata)
    );

    // tree size memory
    wufu_ram #(
        .DEPTH (NODES),
        .WIDTH (SIZE_W)
    ) u_sz_ram (
        .i_clk   (i_clk),
        .i_ctl   (sz_ctl),
        .i_raddr (sz_raddr),
        .i_waddr (sz_waddr),
        .i_wdata (sz_wdata),
        .o_rdata (sz_rdata)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_conn <= res.conn;
            r_out_root <= res.root;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.already_connected = r_out_conn;
    assign o_rsp.common_root       = r_out_root;

endmodule

>>> design/wufu_checker.sv
// ----------------------------------------------------------------------------
// wufu_checker
// port-level checks of the weighted union-find unit, bound to the top level
// ----------------------------------------------------------------------------
`include "weighted_union_find_unit_defines.svh"

module wufu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_out_conn,
    input  logic [wufu_pkg::NODE_W-1:0]   i_out_root
);
    import wufu_pkg::*;

    // a held result keeps its payload
    `WUFU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_conn) && $stable(i_out_root), "result item dropped or changed while stalled")

    // reset starts the clearing pass, no item taken right after
    `WUFU_ASSERT_NEXT_NR(a_rst_busy, i_clk, !i_rst_n, !i_in_ready, "ready right after reset")

    // one item at a time
    `WUFU_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "item taken while another is at work")

    // a result never shows up the cycle after its item is taken
    `WUFU_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid, "result item appeared without root walks")

endmodule

bind weighted_union_find_unit wufu_checker u_wufu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_conn  (o_rsp.already_connected),
    .i_out_root  (o_rsp.common_root)
);
